@@ rtl/srs3_pkg.sv @@
`default_nettype none

package srs3_pkg;

    localparam int unsigned POS_W    = 9;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned NIB_W    = 4;
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned RK_W     = 2;

    localparam logic [POS_W-1:0]  LAST_POS   = 9'd511;
    localparam logic [BYTE_W-1:0] LAST_ADDR_BYTE = 8'd5;
    localparam logic [NIB_W-1:0]  TYPE_S3    = 4'd3;
    localparam logic [NIB_W-1:0]  TYPE_S7    = 4'd7;

    // record kind codes in the line status
    localparam logic [RK_W-1:0] RK_S3    = 2'd0;
    localparam logic [RK_W-1:0] RK_S7    = 2'd1;
    localparam logic [RK_W-1:0] RK_OTHER = 2'd2;

    // result kind codes
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] byte_address;
        logic [BYTE_W-1:0] data_byte;
        logic [RK_W-1:0]   record_kind;
        logic              checksum_ok;
        logic              bad_char;
    } t_result;

    // uppercase hex digit to nibble; bit 4 flags a valid digit
    function automatic logic [NIB_W:0] hex_nibble(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] d;
        begin
            d = '0;
            if (c >= 8'h30 && c <= 8'h39) begin
                d = c - 8'h30;
                hex_nibble = {1'b1, d[NIB_W-1:0]};
            end else if (c >= 8'h41 && c <= 8'h46) begin
                d = c - 8'h37;
                hex_nibble = {1'b1, d[NIB_W-1:0]};
            end else begin
                hex_nibble = '0;
            end
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/srs3_line_core.sv @@
`default_nettype none

module srs3_line_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_step,
    input  wire logic [srs3_pkg::BYTE_W-1:0] i_ch,
    input  wire logic                        i_line_end,
    output srs3_pkg::t_result                o_res,
    output logic                             o_res_valid
);
    import srs3_pkg::*;

    logic [POS_W-1:0]  r_pos,    n_pos;
    logic [NIB_W-1:0]  r_type,   n_type;
    logic [BYTE_W-1:0] r_count,  n_count;
    logic [ADDR_W-1:0] r_addr,   n_addr;
    logic [BYTE_W-1:0] r_sum,    n_sum;
    logic [NIB_W-1:0]  r_hi,     n_hi;
    logic [BYTE_W-1:0] r_idx,    n_idx;
    logic [BYTE_W-1:0] r_cksum,  n_cksum;
    logic              r_err,    n_err;
    logic              r_overrun, n_overrun;

    logic [NIB_W:0]    dec;
    logic [BYTE_W-1:0] cur_byte;
    logic [BYTE_W-1:0] byte_no;
    logic [POS_W:0]    pos_limit;
    logic              in_record;
    logic              have_data;

    always_comb begin
        dec       = hex_nibble(i_ch);
        cur_byte  = {r_hi, dec[NIB_W-1:0]};
        byte_no   = r_pos[POS_W-1:1];
        // last character of the record is the low nibble of byte count+1
        pos_limit = {1'b0, r_count, 1'b0} + 10'd3;
        in_record = !r_overrun && ({1'b0, r_pos} <= pos_limit);

        n_pos     = r_pos;
        n_type    = r_type;
        n_count   = r_count;
        n_addr    = r_addr;
        n_sum     = r_sum;
        n_hi      = r_hi;
        n_idx     = r_idx;
        n_cksum   = r_cksum;
        n_err     = r_err;
        n_overrun = r_overrun;
        have_data = 1'b0;

        if (in_record) begin
            if (r_pos != '0) begin
                if (!dec[NIB_W]) begin
                    n_err = 1'b1;
                end
                if (r_pos == 9'd1) begin
                    n_type = dec[NIB_W-1:0];
                end else if (!r_pos[0]) begin
                    n_hi = dec[NIB_W-1:0];
                end else if (byte_no == 8'd1) begin
                    n_count = cur_byte;
                    n_sum   = r_sum + cur_byte;
                end else if ({1'b0, byte_no} == ({1'b0, r_count} + 9'd1)) begin
                    n_cksum = cur_byte;
                end else begin
                    n_sum = r_sum + cur_byte;
                    if (byte_no <= LAST_ADDR_BYTE) begin
                        n_addr = {r_addr[ADDR_W-BYTE_W-1:0], cur_byte};
                    end else begin
                        have_data = (r_type == TYPE_S3);
                        n_idx     = r_idx + 8'd1;
                    end
                end
            end
            if (r_pos == LAST_POS) begin
                n_overrun = 1'b1;
            end else begin
                n_pos = r_pos + 9'd1;
            end
        end
    end

    always_comb begin
        o_res       = '0;
        o_res_valid = i_line_end || have_data;
        if (i_line_end) begin
            o_res.kind        = KIND_STATUS;
            o_res.record_kind = (n_type == TYPE_S3) ? RK_S3 :
                                (n_type == TYPE_S7) ? RK_S7 : RK_OTHER;
            o_res.checksum_ok = (~n_sum == n_cksum);
            o_res.bad_char    = n_err;
        end else begin
            o_res.kind         = KIND_DATA;
            o_res.byte_address = r_addr + {{(ADDR_W-BYTE_W){1'b0}}, r_idx};
            o_res.data_byte    = cur_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_line_end)) begin
            r_pos     <= '0;
            r_type    <= '0;
            r_count   <= '0;
            r_addr    <= '0;
            r_sum     <= '0;
            r_hi      <= '0;
            r_idx     <= '0;
            r_cksum   <= '0;
            r_err     <= 1'b0;
            r_overrun <= 1'b0;
        end else if (i_step) begin
            r_pos     <= n_pos;
            r_type    <= n_type;
            r_count   <= n_count;
            r_addr    <= n_addr;
            r_sum     <= n_sum;
            r_hi      <= n_hi;
            r_idx     <= n_idx;
            r_cksum   <= n_cksum;
            r_err     <= n_err;
            r_overrun <= n_overrun;
        end
    end

    a_overrun_at_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overrun |-> r_pos == LAST_POS)
        else $error("overrun flag set away from last position");

    a_line_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_line_end |=> r_pos == '0 && !r_err && r_sum == '0)
        else $error("line state not cleared after status");

    a_data_only_s3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        have_data |-> r_type == TYPE_S3 && r_pos[0] && r_idx < r_count)
        else $error("data byte outside an S3 data field");

endmodule

`default_nettype wire

@@ rtl/srecord_s3_line_parser.sv @@
// S3 S-record line parser.
// Input channel: one ASCII character per word on i_ch, i_line_end high on the
// last character of a line. A word is taken when i_valid is high and o_stall
// is low. Output channel: one result per word on o_valid, taken when i_stall
// is low. o_kind 0 is a data byte of an S3 line with its load address;
// o_kind 1 is the line status (record kind, checksum match, bad character)
// given on the last character of each line. Characters that give no result
// (high data nibbles, non-S3 data, all other fields) only update line state.
// Results are registered: a result appears on o_valid the cycle after its
// character is taken. One character is accepted every cycle unless o_stall
// is high; the decode, 8-bit sum and 32-bit address add sit between the
// line state and the output register. o_stall rises only while a result
// is held and the receiver stalls; held results keep their value.
// Reset (synchronous, i_rst_n low) clears the line state and drops o_valid;
// the next character is taken as the start of a new line.
`default_nettype none

module srecord_s3_line_parser (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [srs3_pkg::BYTE_W-1:0] i_ch,
    input  wire logic                        i_line_end,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic                             o_kind,
    output logic [srs3_pkg::ADDR_W-1:0]      o_byte_address,
    output logic [srs3_pkg::BYTE_W-1:0]      o_data_byte,
    output logic [srs3_pkg::RK_W-1:0]        o_record_kind,
    output logic                             o_checksum_ok,
    output logic                             o_bad_char
);
    import srs3_pkg::*;

    t_result r_res;
    logic    r_valid;
    t_result res;
    logic    res_valid;
    logic    step;

    assign o_stall = r_valid && i_stall;
    assign step    = i_valid && !o_stall;

    srs3_line_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_ch        (i_ch),
        .i_line_end  (i_line_end),
        .o_res       (res),
        .o_res_valid (res_valid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= step && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_res <= res;
        end
    end

    assign o_valid        = r_valid;
    assign o_kind         = r_res.kind;
    assign o_byte_address = r_res.byte_address;
    assign o_data_byte    = r_res.data_byte;
    assign o_record_kind  = r_res.record_kind;
    assign o_checksum_ok  = r_res.checksum_ok;
    assign o_bad_char     = r_res.bad_char;

    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_STATUS |-> o_byte_address == '0 && o_data_byte == '0)
        else $error("status word carries data fields");

    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_DATA |->
            o_record_kind == RK_S3 && !o_checksum_ok && !o_bad_char)
        else $error("data word carries status fields");

    a_end_gives_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && i_line_end |=> o_valid && o_kind == KIND_STATUS)
        else $error("line end produced no status");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_record_kind != 2'd3)
        else $error("record kind out of range");

endmodule

`default_nettype wire
